/* sv/assert_macros.svh */
// Assertion macros shared by the serializer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assertion on the block clock clk_i and reset rst_ni.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* sv/tws_pkg.sv */
// Shared types, constants and the command word builder of the two-wire serializer.
`timescale 1ns / 1ps

package tws_pkg;

  localparam int CMD_W        = 16;
  localparam int FRAME_BITS_DEF = 16;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_VOLUME = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TICKS = 2'd0,
    CFG_HALF_BIT    = 2'd1,
    CFG_STOP_TICKS  = 2'd2,
    CFG_BUSY_LINE   = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] START_TICKS_RST = 16'd2000;
  localparam logic [15:0] HALF_BIT_RST    = 16'd100;
  localparam logic [15:0] STOP_TICKS_RST  = 16'd2000;

  localparam logic [CMD_W-1:0] PLAY_MAX    = 16'd511;
  localparam logic [CMD_W-1:0] STOP_WORD   = 16'hFFFF;
  localparam logic [CMD_W-1:0] VOLUME_BASE = 16'hFFF0;
  localparam logic [7:0]       VOLUME_MAX  = 8'd7;

  typedef struct packed {
    logic [15:0] start_ticks;
    logic [15:0] half_bit_ticks;
    logic [15:0] stop_ticks;
  } tws_timing_t;

  typedef struct packed {
    logic clk_level;
    logic data_level;
    logic sending;
    logic rejected;
  } tws_status_t;

  // Command word for a play, stop or volume item.
  function automatic logic [CMD_W-1:0] cmd_word(input logic [MODE_W-1:0] mode,
                                                input logic [CMD_W-1:0] value);
    logic [7:0]       vol;
    logic [CMD_W-1:0] word;
    vol  = value[7:0];
    word = STOP_WORD;
    case (mode)
      MODE_PLAY:   word = (value > PLAY_MAX) ? PLAY_MAX : value;
      MODE_VOLUME: word = VOLUME_BASE | CMD_W'((vol > VOLUME_MAX) ? VOLUME_MAX : vol);
      default:     word = STOP_WORD;
    endcase
    return word;
  endfunction

endpackage

/* sv/tws_fsm.sv */
// Frame sequencer: phase, tick counter, shift word and line levels.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tws_fsm #(
  parameter int FRAME_BITS = tws_pkg::FRAME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [tws_pkg::MODE_W-1:0]  mode_i,
  input  logic [tws_pkg::CMD_W-1:0]   value_i,
  input  tws_pkg::tws_timing_t        timing_i,
  output tws_pkg::tws_status_t        status_o
);
  import tws_pkg::*;

  localparam int BITS_W = $clog2(FRAME_BITS + 1);
  localparam int EXT_W  = (FRAME_BITS > CMD_W) ? FRAME_BITS : CMD_W;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_LOW   = 3'd2;
  localparam logic [2:0] PH_HIGH  = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  logic [2:0]            phase_q, phase_d;
  logic [15:0]           tick_q, tick_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [BITS_W-1:0]     bits_q, bits_d;
  logic                  clk_lvl_q, clk_lvl_d;
  logic                  data_lvl_q, data_lvl_d;
  logic                  rejected;
  logic [15:0]           tick_inc;
  logic [15:0]           limit;
  logic                  done;
  logic [BITS_W-1:0]     bits_inc;
  logic [EXT_W-1:0]      word_ext;

  assign tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign bits_inc = bits_q + BITS_W'(1);
  assign word_ext = EXT_W'(cmd_word(mode_i, value_i));

  always_comb begin
    case (phase_q)
      PH_START: limit = timing_i.start_ticks;
      PH_STOP:  limit = timing_i.stop_ticks;
      default:  limit = timing_i.half_bit_ticks;
    endcase
  end

  // A zero limit behaves as one tick since the incremented count is never below it.
  assign done = (tick_inc >= limit);

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    clk_lvl_d  = clk_lvl_q;
    data_lvl_d = data_lvl_q;
    rejected   = 1'b0;
    if (accept_i) begin
      if (mode_i == MODE_TICK) begin
        if (phase_q != PH_IDLE) begin
          tick_d = done ? 16'd0 : tick_inc;
        end
        unique case (phase_q)
          PH_START: begin
            if (done) begin
              phase_d   = PH_LOW;
              clk_lvl_d = 1'b0;
            end
          end
          PH_LOW: begin
            if (done) begin
              data_lvl_d = shift_q[FRAME_BITS-1];
              clk_lvl_d  = 1'b1;
              phase_d    = PH_HIGH;
            end
          end
          PH_HIGH: begin
            if (done) begin
              shift_d = shift_q << 1;
              bits_d  = bits_inc;
              if (bits_inc == BITS_W'(FRAME_BITS)) begin
                phase_d = PH_STOP;
              end else begin
                phase_d   = PH_LOW;
                clk_lvl_d = 1'b0;
              end
            end
          end
          PH_STOP: begin
            if (done) begin
              phase_d = PH_IDLE;
            end
          end
          default: ;
        endcase
      end else if (phase_q != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        shift_d   = word_ext[FRAME_BITS-1:0];
        bits_d    = '0;
        tick_d    = '0;
        clk_lvl_d = 1'b0;
        phase_d   = PH_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      shift_q    <= '0;
      bits_q     <= '0;
      clk_lvl_q  <= 1'b1;
      data_lvl_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      clk_lvl_q  <= clk_lvl_d;
      data_lvl_q <= data_lvl_d;
    end
  end

  assign status_o.clk_level  = clk_lvl_d;
  assign status_o.data_level = data_lvl_d;
  assign status_o.sending    = (phase_d != PH_IDLE);
  assign status_o.rejected   = rejected;

  `ASSERT_STD(a_clk_low_phases, (phase_q == PH_START || phase_q == PH_LOW) |-> !clk_lvl_q, "clock must be low in start and low half")
  `ASSERT_STD(a_clk_high_phases, (phase_q == PH_IDLE || phase_q == PH_HIGH || phase_q == PH_STOP) |-> clk_lvl_q, "clock must be high when idle, in high half and stop")
  `ASSERT_STD(a_reject_holds_word, (accept_i && mode_i != MODE_TICK && phase_q != PH_IDLE) |=> $stable(shift_q), "rejected command altered the frame")

endmodule

/* sv/two_wire_command_serializer_top.sv */
// Top level of the two-wire command serializer: config registers, sequencer and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Two-wire command serializer. Each input beat is either a time tick (mode 0) or a command
// (play, stop, volume); every accepted beat yields exactly one result beat carrying the clock
// and data line levels after that beat, a sending flag, a rejected flag for commands that
// arrived mid-frame, and the busy pin level when a busy line is fitted. A command taken while
// idle starts a frame: clock low for start_ticks ticks, then FRAME_BITS bits MSB first (clock
// low for half_bit_ticks, data set and clock high for half_bit_ticks), then clock high for
// stop_ticks ticks. Only tick beats advance time; a duration register of zero counts as one.
// One beat per clock cycle is taken while in_stall_o is low; the sequencer state and result
// register both update at the edge accepting a beat, so the result is valid the cycle after.
// The single result register is the only buffering; in_stall_o rises only while a result is
// held there and downstream stalls. The user must write configuration through cfg_we_i,
// cfg_index_i and cfg_data_i while the block is quiet, which the block leaves unchecked; no clearing pass after reset.
module two_wire_command_serializer_top #(
  parameter int FRAME_BITS = tws_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tws_pkg::MODE_W-1:0]    mode_i,
  input  logic [tws_pkg::CMD_W-1:0]     value_i,
  input  logic                          busy_pin_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          clk_out_o,
  output logic                          data_out_o,
  output logic                          sending_o,
  output logic                          rejected_o,
  output logic                          module_busy_o
);
  import tws_pkg::*;

  tws_timing_t timing_q;
  logic        busy_present_q;
  logic        in_accept;
  tws_status_t status_next;
  logic        out_valid_q;
  tws_status_t status_q;
  logic        module_busy_q;

  // Configuration registers; each of the four indexes selects one register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.start_ticks    <= START_TICKS_RST;
      timing_q.half_bit_ticks <= HALF_BIT_RST;
      timing_q.stop_ticks     <= STOP_TICKS_RST;
      busy_present_q          <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_TICKS: timing_q.start_ticks    <= cfg_data_i;
        CFG_HALF_BIT:    timing_q.half_bit_ticks <= cfg_data_i;
        CFG_STOP_TICKS:  timing_q.stop_ticks     <= cfg_data_i;
        CFG_BUSY_LINE:   busy_present_q          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The input is held off only while a finished result is waiting and downstream stalls.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  tws_fsm #(
    .FRAME_BITS (FRAME_BITS)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .mode_i   (mode_i),
    .value_i  (value_i),
    .timing_i (timing_q),
    .status_o (status_next)
  );

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q      <= status_next;
      module_busy_q <= busy_present_q & busy_pin_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign clk_out_o     = status_q.clk_level;
  assign data_out_o    = status_q.data_level;
  assign sending_o     = status_q.sending;
  assign rejected_o    = status_q.rejected;
  assign module_busy_o = module_busy_q;

  `ASSERT_STD(a_accept_gives_result, in_accept |=> out_valid_o, "accepted beat produced no result")
  `ASSERT_STD(a_reject_while_sending, (out_valid_o && rejected_o) |-> sending_o, "reject reported outside a frame")
  `ASSERT_STD(a_idle_clock_high, (out_valid_o && !sending_o) |-> clk_out_o, "clock line low while idle")

endmodule

/* verif/tb_two_wire_command_serializer_top.sv */
// Self-checking testbench of the two-wire command serializer, with its own line predictor.
`timescale 1ns / 1ps

module tb_two_wire_command_serializer_top;
  import tws_pkg::*;

  localparam int FRAME_LEN = FRAME_BITS_DEF;
  localparam int LONG_HOLD = 64;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_BEATS = 50;

  // Where the predicted line sits within a frame.
  typedef enum logic [2:0] {
    LINE_IDLE,
    LINE_START,
    LINE_LOW,
    LINE_HIGH,
    LINE_STOP
  } line_phase_e;

  // Levels reported by one result beat.
  typedef struct packed {
    logic clk_level;
    logic data_level;
    logic sending;
    logic rejected;
    logic module_busy;
  } line_levels_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [MODE_W-1:0]    mode_i;
  logic [CMD_W-1:0]     value_i;
  logic                 busy_pin_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 clk_out_o;
  logic                 data_out_o;
  logic                 sending_o;
  logic                 rejected_o;
  logic                 module_busy_o;

  two_wire_command_serializer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .busy_pin_i    (busy_pin_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .clk_out_o     (clk_out_o),
    .data_out_o    (data_out_o),
    .sending_o     (sending_o),
    .rejected_o    (rejected_o),
    .module_busy_o (module_busy_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Predicted register contents and line state.
  logic [15:0]  start_len;
  logic [15:0]  half_bit_len;
  logic [15:0]  stop_len;
  logic         busy_fitted;
  line_phase_e  line_phase;
  int unsigned  tick_cnt;
  logic [31:0]  cmd_shift;
  int unsigned  bits_out;
  logic         clk_level;
  logic         data_level;

  line_levels_t expected_levels[$];

  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit holding = 1'b0;

  int beats_sent = 0;
  int results_seen = 0;
  int frames_started = 0;
  int commands_refused = 0;
  int mismatches = 0;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Counts one tick, saturating, and says whether the given length has run out.
  // A length of zero runs out on the first tick, just as a length of one does.
  function automatic logic timer_expired(input logic [15:0] len);
    if (tick_cnt < 32'hFFFF) tick_cnt++;
    if (tick_cnt >= len) begin
      tick_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_line();
    case (line_phase)
      LINE_START: begin
        if (timer_expired(start_len)) begin
          line_phase = LINE_LOW;
          clk_level  = 1'b0;
        end
      end
      LINE_LOW: begin
        if (timer_expired(half_bit_len)) begin
          data_level = cmd_shift[FRAME_LEN-1];
          clk_level  = 1'b1;
          line_phase = LINE_HIGH;
        end
      end
      LINE_HIGH: begin
        if (timer_expired(half_bit_len)) begin
          cmd_shift = cmd_shift << 1;
          bits_out++;
          if (bits_out >= FRAME_LEN) begin
            line_phase = LINE_STOP;
          end else begin
            line_phase = LINE_LOW;
            clk_level  = 1'b0;
          end
        end
      end
      LINE_STOP: begin
        if (timer_expired(stop_len)) line_phase = LINE_IDLE;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] command_word(input logic [MODE_W-1:0] mode,
                                                    input logic [CMD_W-1:0] value);
    logic [7:0] level;
    level = value[7:0];
    case (mode)
      MODE_PLAY:   return (value > PLAY_MAX) ? PLAY_MAX : value;
      MODE_VOLUME: return VOLUME_BASE | {8'h00, (level > VOLUME_MAX) ? VOLUME_MAX : level};
      default:     return STOP_WORD;
    endcase
  endfunction

  // Applies one accepted beat to the predicted line and returns the levels it should report.
  function automatic line_levels_t step_line(input logic [MODE_W-1:0] mode,
                                             input logic [CMD_W-1:0] value,
                                             input logic busy);
    line_levels_t lv;
    logic         refused;
    refused = 1'b0;
    if (mode == MODE_TICK) begin
      advance_line();
    end else if (line_phase != LINE_IDLE) begin
      refused = 1'b1;
      commands_refused++;
    end else begin
      cmd_shift  = {16'h0000, command_word(mode, value)};
      bits_out   = 0;
      tick_cnt   = 0;
      clk_level  = 1'b0;
      line_phase = LINE_START;
      frames_started++;
    end
    lv.clk_level   = clk_level;
    lv.data_level  = data_level;
    lv.sending     = (line_phase != LINE_IDLE);
    lv.rejected    = refused;
    lv.module_busy = busy_fitted & busy;
    return lv;
  endfunction

  // Offers one beat and holds it until taken; valid is left high for a following beat.
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [CMD_W-1:0] value,
                           input logic busy);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    busy_pin_i <= busy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_levels.push_back(step_line(mode, value, busy));
    beats_sent++;
  endtask

  task automatic finish_frame();
    while (line_phase != LINE_IDLE) send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_START_TICKS: start_len    = data;
      CFG_HALF_BIT:    half_bit_len = data;
      CFG_STOP_TICKS:  stop_len     = data;
      default:         busy_fitted  = data[0];
    endcase
  endtask

  // Stops offering beats, waits for every result, then rewrites the three lengths.
  // The write enable is left high; the caller drops it.
  task automatic write_lengths(input logic [15:0] start, input logic [15:0] half,
                               input logic [15:0] stop);
    in_valid_i <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    write_reg(CFG_START_TICKS, start);
    write_reg(CFG_HALF_BIT, half);
    write_reg(CFG_STOP_TICKS, stop);
  endtask

  // Brings the line to rest, waits for every result, then rewrites all four registers.
  task automatic program_line(input logic [15:0] start, input logic [15:0] half,
                              input logic [15:0] stop, input logic busy);
    finish_frame();
    write_lengths(start, half, stop);
    write_reg(CFG_BUSY_LINE, {15'($urandom), busy});
    cfg_we_i <= 1'b0;
  endtask

  // Reset lengths: idle ticks change nothing, a stop frame starts and a play is refused.
  // The start and low halves run against their reset lengths before shorter ones are set.
  task automatic test_reset_timing();
    send_beat(MODE_TICK, 16'hFFFF, 1'b1);
    send_beat(MODE_TICK, 16'h0000, 1'b0);
    send_beat(MODE_STOP, 16'($urandom), 1'b1);
    send_beat(MODE_PLAY, 16'h0005, 1'b1);
    repeat (12) send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
    // The start count is already past the new start length, so the next tick ends it.
    write_lengths(16'd1, HALF_BIT_RST, STOP_TICKS_RST);
    cfg_we_i <= 1'b0;
    repeat (8) send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
    write_lengths(16'd1, 16'd1, 16'd1);
    cfg_we_i <= 1'b0;
    finish_frame();
  endtask

  // Clamping of play and volume values, and a refused command in each frame.
  task automatic test_command_words();
    logic [MODE_W-1:0] modes[4];
    logic [CMD_W-1:0]  values[4];
    modes  = '{MODE_PLAY, MODE_PLAY, MODE_VOLUME, MODE_VOLUME};
    values = '{16'h01A5, 16'd512, 16'h0008, 16'hFF03};
    program_line(16'd1, 16'd1, 16'd1, 1'b1);
    for (int i = 0; i < 4; i++) begin
      send_beat(modes[i], values[i], 1'($urandom));
      send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
      send_beat(MODE_W'($urandom_range(1, 3)), 16'($urandom), 1'($urandom));
      finish_frame();
    end
  endtask

  // Every timing register at zero must behave as a length of one.
  task automatic test_zero_lengths();
    program_line(16'd0, 16'd0, 16'd0, 1'b0);
    send_beat(MODE_PLAY, 16'($urandom), 1'b1);
    finish_frame();
  endtask

  // The sink holds off for a long stretch while beats keep coming, so the input stalls.
  task automatic test_input_backpressure();
    program_line(16'd2, 16'd1, 16'd2, 1'b1);
    hold_req = 1'b1;
    wait (holding);
    src_idle_on = 1'b0;
    send_beat(MODE_PLAY, 16'($urandom), 1'($urandom));
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_beat(MODE_W'($urandom_range(1, 3)), 16'($urandom), 1'($urandom));
      else
        send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
    end
    src_idle_on = 1'b1;
  endtask

  // Lengths of 65535 in every phase; the start, low and stop phases are cut short by shorter lengths set mid-frame.
  task automatic test_long_lengths();
    program_line(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_beat(MODE_VOLUME, 16'($urandom), 1'($urandom));
    repeat (6) send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
    write_lengths(16'd1, 16'hFFFF, 16'hFFFF);
    cfg_we_i <= 1'b0;
    repeat (6) send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
    write_lengths(16'd1, 16'd1, 16'hFFFF);
    cfg_we_i <= 1'b0;
    while (line_phase != LINE_STOP) send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
    repeat (4) send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
    write_lengths(16'd1, 16'd1, 16'd1);
    cfg_we_i <= 1'b0;
    finish_frame();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Command values lean towards the clamp boundaries and the all-zero and all-one words.
  function automatic logic [CMD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 7));
      1:       return 16'($urandom_range(505, 520));
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly whole frames with random content, with commands thrown in mid-frame as noise.
  task automatic test_random_traffic();
    for (int s = 0; s < 2; s++) begin
      case (s)
        0:       program_line(16'd1, 16'd1, 16'd1, 1'b1);
        default: program_line(16'($urandom_range(1, 3)), 16'($urandom_range(1, 2)),
                              16'($urandom_range(1, 3)), 1'($urandom));
      endcase
      for (int i = 0; i < RANDOM_BEATS; i++) begin
        if (i % 25 == 0) begin
          src_idle_on  = ($urandom_range(0, 3) != 0);
          sink_idle_on = ($urandom_range(0, 3) != 0);
        end
        if ((line_phase == LINE_IDLE) ? ($urandom_range(0, 3) != 0)
                                      : ($urandom_range(0, 99) < 12))
          send_beat(MODE_W'($urandom_range(1, 3)), pick_value(), 1'($urandom));
        else
          send_beat(MODE_TICK, 16'($urandom), 1'($urandom));
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Sink side: random stalls, plus one long hold-off when asked for.
  initial begin : sink_side
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        holding = 1'b0;
      end else begin
        n = sink_idle_on ? pick_gap() : 0;
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("mismatch on %s at result %0d: expected %b, got %b",
                 name, results_seen, want, got);
    end
  endtask

  always @(posedge clk_i) begin : line_checker
    line_levels_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result beat %0d arrived with nothing expected", results_seen);
      end else begin
        want = expected_levels.pop_front();
        compare_field("clk_out", want.clk_level, clk_out_o);
        compare_field("data_out", want.data_level, data_out_o);
        compare_field("sending", want.sending, sending_o);
        compare_field("rejected", want.rejected, rejected_o);
        compare_field("module_busy", want.module_busy, module_busy_o);
      end
      results_seen++;
    end
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_START_TICKS;
    cfg_data_i   = 16'h0000;
    in_valid_i   = 1'b0;
    mode_i       = MODE_TICK;
    value_i      = '0;
    busy_pin_i   = 1'b0;
    start_len    = START_TICKS_RST;
    half_bit_len = HALF_BIT_RST;
    stop_len     = STOP_TICKS_RST;
    busy_fitted  = 1'b0;
    line_phase   = LINE_IDLE;
    tick_cnt     = 0;
    cmd_shift    = '0;
    bits_out     = 0;
    clk_level    = 1'b1;
    data_level   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_timing();
    test_command_words();
    test_zero_lengths();
    test_input_backpressure();
    test_long_lengths();
    test_random_traffic();

    in_valid_i <= 1'b0;
    sink_idle_on = 1'b0;
    for (int i = 0; i < 1000 && expected_levels.size() != 0; i++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_levels.size() != 0) begin
      $display("%0d expected result beats never arrived", expected_levels.size());
      mismatches++;
    end
    $display("run covered %0d input beats and %0d result beats: %0d frames, %0d refused",
             beats_sent, results_seen, frames_started, commands_refused);
    $display("lengths ran from zero to 65535 ticks, some cut short mid-frame, busy line on and off");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/tws_pkg.sv
sv/tws_fsm.sv
sv/two_wire_command_serializer_top.sv
verif/tb_two_wire_command_serializer_top.sv
